>>> rtl/nrpr_pkg.sv
// Package: shared types, constants and helpers for the Newton-Raphson root unit.
package nrpr_pkg;
  localparam int unsigned NrprMaxDegree = 8;
  localparam int unsigned NrprMaxSteps  = 32;
  localparam int unsigned QW = 32;
  localparam logic [3:0] CfgDegree = 4'd0;
  localparam logic [3:0] CfgTol    = 4'd1;
  localparam logic [3:0] CfgLimit  = 4'd2;

  localparam logic [2:0] StContinue = 3'd0;
  localparam logic [2:0] StExact    = 3'd1;
  localparam logic [2:0] StTol      = 3'd2;
  localparam logic [2:0] StLimit    = 3'd3;
  localparam logic [2:0] StZeroDer  = 3'd4;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -66'sh0_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction
endpackage

>>> rtl/newton_raphson_poly_root_unit.sv
// Top level: Newton-Raphson polynomial root finder sequencer.
// Load word: the coefficient is written as the word is taken, and the input stays ready.
// Solve word: each step runs the Horner passes and control on the shared multiply unit,
// then a division and the registering of the output word; a zero slope skips the division
// and the f(x1) pass. Up to iteration_limit steps, one output word per step.
// Reset (async, active low) clears coefficients and restores register defaults.
module newton_raphson_poly_root_unit import nrpr_pkg::*; #(
  parameter int unsigned MAX_DEGREE = NrprMaxDegree,
  parameter int unsigned MAX_STEPS  = NrprMaxSteps
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [3:0]   cfg_idx_i,
  input  logic [30:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: coef_index[3:0], coef_value[35:4], start_guess[67:36], zero fill
  input  logic [71:0]  s_axis_tdata,
  // tuser: cmd
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: iteration[5:0], x_old[37:6], f_value[69:38], slope_value[101:70],
  //        x_new[133:102], zero fill
  output logic [135:0] m_axis_tdata,
  // tuser: status
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast
);
  localparam int unsigned DW = $clog2(MAX_DEGREE + 1);
  localparam int unsigned SW = $clog2(MAX_STEPS + 1);
  localparam int unsigned PW = DW + 33;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001, S_INIT = 8'b0000_0010, S_MUL  = 8'b0000_0100,
    S_ACC  = 8'b0000_1000, S_DIV  = 8'b0001_0000, S_WAITD = 8'b0010_0000,
    S_OUT  = 8'b0100_0000, S_COEF = 8'b1000_0000
  } state_e;

  // pass 0: f(x0), pass 1: f'(x0), pass 2: f(x1)
  state_e state_q, state_d;
  logic signed [31:0] coef_q [MAX_DEGREE+1];
  logic [3:0]  deg_cfg_q;
  logic [30:0] tol_q;
  logic [5:0]  lim_cfg_q;
  logic [DW-1:0] deg_q, idx_q;
  logic [SW-1:0] lim_q, step_q;
  logic [1:0]  pass_q;
  logic signed [31:0] x0_q, x1_q, f_q, g_q, acc_q, xe;
  logic signed [31:0] dcoef;
  logic signed [PW-1:0] dprod;
  logic [2:0]  st_q;
  logic        last_q;
  logic signed [31:0] mac_res, cf;
  logic        div_done;
  logic signed [48:0] quo;
  logic        div_start;
  logic [3:0]  in_idx;
  logic signed [31:0] in_val, in_guess;

  assign in_idx   = s_axis_tdata[3:0];
  assign in_val   = s_axis_tdata[35:4];
  assign in_guess = s_axis_tdata[67:36];
  assign s_axis_tready = (state_q == S_IDLE);
  assign xe = (pass_q == 2'd2) ? x1_q : x0_q;
  assign div_start = (state_q == S_DIV);

  // derivative coefficient i*c_i at the current index, registered inside the shared unit
  assign dprod = PW'($signed({1'b0, idx_q})) * PW'(coef_q[idx_q]);
  assign dcoef = sat32(66'(dprod));
  assign cf = (pass_q == 2'd1) ? dcoef : coef_q[idx_q - DW'(1)];

  nrpr_mac u_mac (.clk_i, .acc_i(acc_q), .x_i(xe), .c_i(cf), .res_o(mac_res));
  nrpr_div u_div (.clk_i, .rst_ni, .start_i(div_start),
                  .num_i({f_q, 16'd0}), .den_i(g_q), .done_o(div_done), .quo_o(quo));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      deg_cfg_q <= 4'd1; tol_q <= 31'd7; lim_cfg_q <= 6'd10;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata <= '0; m_axis_tuser <= StContinue; m_axis_tlast <= 1'b0;
      for (int i = 0; i <= MAX_DEGREE; i++) coef_q[i] <= '0;
      pass_q <= '0; idx_q <= '0; step_q <= '0; deg_q <= '0; lim_q <= '0;
      x0_q <= '0; x1_q <= '0; f_q <= '0; g_q <= '0; acc_q <= '0;
      st_q <= StContinue; last_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgDegree: deg_cfg_q <= cfg_wdata_i[3:0];
          CfgTol:    tol_q     <= cfg_wdata_i;
          CfgLimit:  lim_cfg_q <= cfg_wdata_i[5:0];
          default: ;
        endcase
      end
      // drop valid once taken, unless a new word is loaded in this cycle
      if (m_axis_tvalid && m_axis_tready && state_q != S_OUT) m_axis_tvalid <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            if (!s_axis_tuser) begin
              if (32'(in_idx) <= MAX_DEGREE) coef_q[DW'(in_idx)] <= in_val;
            end else begin
              deg_q <= (32'(deg_cfg_q) > MAX_DEGREE) ? DW'(MAX_DEGREE) : DW'(deg_cfg_q);
              lim_q <= (lim_cfg_q == 6'd0) ? SW'(1) :
                       (32'(lim_cfg_q) > MAX_STEPS) ? SW'(MAX_STEPS) : SW'(lim_cfg_q);
              x0_q <= in_guess;
              step_q <= SW'(1);
              state_q <= S_INIT;
              pass_q <= 2'd0;
            end
          end
        end
        S_INIT: begin
          // seed acc with top coef for f; f' seeds in S_COEF, or flags zero slope at degree 0
          if (pass_q == 2'd1) begin
            if (deg_q == '0) begin
              g_q <= '0;
              state_q <= S_OUT;
              x1_q <= x0_q;
              st_q <= StZeroDer; last_q <= 1'b1;
            end else begin
              idx_q <= deg_q;
              state_q <= S_COEF;
            end
          end else begin
            acc_q <= coef_q[deg_q];
            idx_q <= deg_q;
            state_q <= (deg_q == '0) ? S_ACC : S_MUL;
          end
        end
        S_COEF: begin
          acc_q <= dcoef;
          state_q <= (idx_q == DW'(1)) ? S_ACC : S_MUL;
          idx_q <= idx_q - DW'(1);
        end
        S_MUL: begin
          // pass 0/2 add c[idx_q-1], pass 1 adds idx_q*c[idx_q]; S_WAITD takes the registered product
          if (pass_q != 2'd1 || idx_q != '0) begin
            if (pass_q != 2'd1) idx_q <= idx_q - DW'(1);
            state_q <= S_WAITD;
          end
        end
        S_WAITD: begin
          acc_q <= mac_res;
          if (pass_q == 2'd1) begin
            if (idx_q == DW'(1)) state_q <= S_ACC;
            else begin idx_q <= idx_q - DW'(1); state_q <= S_MUL; end
          end else begin
            if (idx_q == '0) state_q <= S_ACC;
            else state_q <= S_MUL;
          end
        end
        S_ACC: begin
          // acc_q holds the finished evaluation
          if (pass_q == 2'd0) begin
            f_q <= acc_q; pass_q <= 2'd1; state_q <= S_INIT;
          end else if (pass_q == 2'd1) begin
            g_q <= acc_q;
            if (acc_q == '0) begin
              x1_q <= x0_q; st_q <= StZeroDer; last_q <= 1'b1; state_q <= S_OUT;
            end else state_q <= S_DIV;
          end else begin
            if (acc_q == '0) begin st_q <= StExact; last_q <= 1'b1; end
            else if ({1'b0, (acc_q[31] ? 32'(-acc_q) : acc_q)} < {2'b0, tol_q}) begin
              st_q <= StTol; last_q <= 1'b1;
            end else if (step_q >= lim_q) begin st_q <= StLimit; last_q <= 1'b1; end
            else begin st_q <= StContinue; last_q <= 1'b0; end
            state_q <= S_OUT;
          end
        end
        S_DIV: begin
          // hold until the quotient is ready, then evaluate f(x1)
          if (div_done) begin
            x1_q <= sat32(66'(x0_q) - 66'(sat32(66'(quo))));
            pass_q <= 2'd2;
            state_q <= S_INIT;
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {2'b0, x1_q, g_q, f_q, x0_q, 6'(step_q)};
            m_axis_tuser  <= st_q;
            m_axis_tlast  <= last_q;
            if (last_q) state_q <= S_IDLE;
            else begin
              x0_q <= x1_q; step_q <= step_q + SW'(1);
              pass_q <= 2'd0; state_q <= S_INIT;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !(state_q == S_DIV)) else $error("ready while dividing");
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == StLimit |-> m_axis_tlast)
    else $error("limit status without last");
`endif
endmodule

>>> rtl/nrpr_div.sv
// Radix-2 restoring divider: signed 48-bit dividend over signed 32-bit divisor, truncating.
module nrpr_div import nrpr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [47:0] num_i,
  input  logic signed [31:0] den_i,
  output logic               done_o,
  output logic signed [48:0] quo_o
);
  logic [47:0] rem_q, rem_d, q_q, q_d;
  logic [31:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic [48:0] trial;

  always_comb begin
    rem_d = rem_q; q_d = q_q; den_d = den_q; neg_d = neg_q;
    cnt_d = cnt_q; run_d = run_q; done_o = 1'b0;
    trial = {rem_q, q_q[47]} - {17'd0, den_q};
    if (start_i && !run_q) begin
      rem_d = '0;
      q_d   = num_i[47] ? 48'(-num_i) : 48'(num_i);
      den_d = den_i[31] ? 32'(-den_i) : 32'(den_i);
      neg_d = num_i[47] ^ den_i[31];
      cnt_d = 6'd48;
      run_d = 1'b1;
    end else if (run_q) begin
      if (!trial[48]) begin
        rem_d = trial[47:0];
        q_d   = {q_q[46:0], 1'b1};
      end else begin
        rem_d = {rem_q[46:0], q_q[47]};
        q_d   = {q_q[46:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        run_d  = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  assign quo_o = neg_q ? -$signed({1'b0, q_d}) : $signed({1'b0, q_d});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; q_q <= q_d; den_q <= den_d; neg_q <= neg_d;
  end
endmodule

>>> rtl/nrpr_mac.sv
// Shared Horner step unit: registered product, then round, saturate and add.
module nrpr_mac import nrpr_pkg::*; (
  input  logic               clk_i,
  input  logic signed [31:0] acc_i,
  input  logic signed [31:0] x_i,
  input  logic signed [31:0] c_i,
  output logic signed [31:0] res_o
);
  logic signed [63:0] prod_q;
  logic signed [31:0] c_q;
  logic signed [47:0] rnd;
  logic signed [31:0] m;

  always_ff @(posedge clk_i) begin
    prod_q <= acc_i * x_i;
    c_q    <= c_i;
  end

  always_comb begin
    rnd   = 48'((prod_q + 64'sd32768) >>> 16);
    m     = sat32(66'(rnd));
    res_o = sat32(66'(m) + 66'(c_q));
  end
endmodule
